FILE: hdl/ddgp_pkg.sv
package ddgp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_X       = 3'd0,
		REG_TARGET_Y       = 3'd1,
		REG_TARGET_HEADING = 3'd2,
		REG_DISTANCE_GAIN  = 3'd3,
		REG_HEADING_GAIN   = 3'd4,
		REG_WHEEL_BASE     = 3'd5,
		REG_WHEEL_RADIUS   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [31:0] pose_heading;
	} pose_t;

	typedef struct packed {
		logic signed [31:0] left_speed;
		logic signed [31:0] right_speed;
	} speeds_t;

	// Square root: 64-bit radicand, one root bit per stage.
	localparam int RAD_W    = 64;
	localparam int ROOT_W   = 32;
	localparam int SQ_REM_W = 34;

	// Turn term w * wheel_base, as sign and magnitude.
	localparam int WL_W  = 55;
	localparam int N_W   = 57;
	localparam int MAG_W = 56;

	// Wheel speed division: 31 quotient bits, one per stage.
	localparam int DEN_W  = 32;
	localparam int QUO_W  = 31;
	localparam int Q_FRAC = 16;
	localparam int MLO_W  = 15;

	typedef struct packed {
		logic            neg;
		logic [WL_W-1:0] mag;
	} wl_t;

	typedef struct packed {
		logic neg;
		logic ovf;
	} dv_side_t;

	typedef struct packed {
		dv_side_t         side;
		logic [DEN_W-1:0] rem0;
		logic [MLO_W-1:0] mlo;
	} dv_prep_t;

endpackage

FILE: hdl/ddgp_sqrt.sv
module ddgp_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_v,
	input  logic [ddgp_pkg::RAD_W-1:0]   rad,
	input  ddgp_pkg::wl_t                side_in,
	output logic                         out_v,
	output logic [ddgp_pkg::ROOT_W-1:0]  root,
	output ddgp_pkg::wl_t                side_out
);
	import ddgp_pkg::*;

	logic                v_s    [ROOT_W];
	logic [SQ_REM_W-1:0] rem_s  [ROOT_W];
	logic [ROOT_W-1:0]   root_s [ROOT_W];
	logic [RAD_W-1:0]    rad_s  [ROOT_W];
	wl_t                 side_s [ROOT_W];

	// Each stage brings down two radicand bits and settles one root bit.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic                pv;
		logic [SQ_REM_W-1:0] prem;
		logic [ROOT_W-1:0]   proot;
		logic [RAD_W-1:0]    prad;
		wl_t                 pside;
		logic [SQ_REM_W+1:0] trial;
		logic [SQ_REM_W+1:0] tst;
		logic                ge;

		if (k == 0) begin : g_first
			assign pv    = in_v;
			assign prem  = '0;
			assign proot = '0;
			assign prad  = rad;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign prad  = rad_s[k-1];
			assign pside = side_s[k-1];
		end

		assign trial = {prem, prad[RAD_W-1-2*k -: 2]};
		assign tst   = {{(SQ_REM_W-ROOT_W){1'b0}}, proot, 2'b01};
		assign ge    = (trial >= tst);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? SQ_REM_W'(trial - tst) : SQ_REM_W'(trial);
				root_s[k] <= {proot[ROOT_W-2:0], ge};
				rad_s[k]  <= prad;
				side_s[k] <= pside;
			end
		end
	end

	assign out_v    = v_s[ROOT_W-1];
	assign root     = root_s[ROOT_W-1];
	assign side_out = side_s[ROOT_W-1];

endmodule

FILE: hdl/ddgp_div.sv
module ddgp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_v,
	input  ddgp_pkg::dv_prep_t          prep,
	input  logic [ddgp_pkg::DEN_W-1:0]  den,
	output logic                        out_v,
	output logic [ddgp_pkg::QUO_W-1:0]  quo,
	output ddgp_pkg::dv_side_t          side_out
);
	import ddgp_pkg::*;

	logic             v_s    [QUO_W];
	logic [DEN_W-1:0] rem_s  [QUO_W];
	logic [QUO_W-1:0] quo_s  [QUO_W];
	logic [MLO_W-1:0] mlo_s  [QUO_W];
	dv_side_t         side_s [QUO_W];

	// Restoring division of |n| * 2^16 by the denominator, one quotient bit per stage.
	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		logic             pv;
		logic [DEN_W-1:0] prem;
		logic [QUO_W-1:0] pquo;
		logic [MLO_W-1:0] pmlo;
		dv_side_t         pside;
		logic             nb;
		logic [DEN_W:0]   sh;
		logic [DEN_W:0]   dx;
		logic             ge;

		if (i == 0) begin : g_first
			assign pv    = in_v;
			assign prem  = prep.rem0;
			assign pquo  = '0;
			assign pmlo  = prep.mlo;
			assign pside = prep.side;
		end else begin : g_next
			assign pv    = v_s[i-1];
			assign prem  = rem_s[i-1];
			assign pquo  = quo_s[i-1];
			assign pmlo  = mlo_s[i-1];
			assign pside = side_s[i-1];
		end

		if (QUO_W-1-i >= Q_FRAC) begin : g_num
			assign nb = pmlo[QUO_W-1-i-Q_FRAC];
		end else begin : g_zero
			assign nb = 1'b0;
		end

		assign sh = {prem, nb};
		assign dx = {1'b0, den};
		assign ge = (sh >= dx);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? DEN_W'(sh - dx) : DEN_W'(sh);
				quo_s[i]  <= {pquo[QUO_W-2:0], ge};
				mlo_s[i]  <= pmlo;
				side_s[i] <= pside;
			end
		end
	end

	assign out_v    = v_s[QUO_W-1];
	assign quo      = quo_s[QUO_W-1];
	assign side_out = side_s[QUO_W-1];

endmodule

FILE: hdl/diff_drive_goto_pose_speeds_top.sv
// Channel  Direction  Handshake               Payload
// pose     in         in_valid / in_ready     in_data  (pose_x, pose_y, pose_heading)
// speeds   out        out_valid / out_ready   out_data (left_speed, right_speed)
// config   in         cfg_we                  cfg_index, cfg_data
//
// One word is taken per cycle while the output holding stage has room; a word passes
// through the 32 root stages, the 31 divider stages, seven arithmetic stages and the
// output register.
// Reset clears the valid bits and the output holding stages and loads the register defaults.
// A stall at the output fills a two-word holding stage; only when both are full does
// the whole pipeline freeze, and in_ready falls with it.
module diff_drive_goto_pose_speeds_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ddgp_pkg::pose_t                  in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ddgp_pkg::speeds_t                out_data,
	input  logic                             cfg_we,
	input  logic [ddgp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ddgp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ddgp_pkg::*;

	// Saturate a 33-bit difference into the signed 32-bit range.
	function automatic logic [31:0] sat33(input logic [32:0] d);
		logic [31:0] r;
		begin
			if (d[32] != d[31]) begin
				r = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				r = d[31:0];
			end
			return r;
		end
	endfunction

	// Split a signed numerator into what the divider needs. Overflow means the
	// quotient is at least 2^31, which saturates for either sign.
	function automatic dv_prep_t prep_lane(input logic [N_W-1:0] n,
	                                       input logic [DEN_W-1:0] den);
		dv_prep_t         p;
		logic [MAG_W-1:0] m;
		begin
			m           = n[N_W-1] ? MAG_W'(-n) : MAG_W'(n);
			p.side.neg  = n[N_W-1];
			p.side.ovf  = (m >= MAG_W'({den, {MLO_W{1'b0}}}));
			p.rem0      = m[DEN_W+MLO_W-1:MLO_W];
			p.mlo       = m[MLO_W-1:0];
			return p;
		end
	endfunction

	// Apply the sign and saturate to a signed 32-bit speed.
	function automatic logic [31:0] finish(input logic [QUO_W-1:0] q, input dv_side_t s);
		logic [31:0] r;
		begin
			if (s.ovf) begin
				r = s.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else if (s.neg) begin
				r = 32'(-{1'b0, q});
			end else begin
				r = {1'b0, q};
			end
			return r;
		end
	endfunction

	// Configuration registers.
	logic [31:0] target_x_q;
	logic [31:0] target_y_q;
	logic [31:0] target_heading_q;
	logic [15:0] distance_gain_q;
	logic [15:0] heading_gain_q;
	logic [30:0] wheel_base_q;
	logic [30:0] wheel_radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q       <= '0;
			target_y_q       <= '0;
			target_heading_q <= '0;
			distance_gain_q  <= 16'd384;
			heading_gain_q   <= 16'd1024;
			wheel_base_q     <= 31'd13107;
			wheel_radius_q   <= 31'd3277;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TARGET_X:       target_x_q       <= cfg_data;
				REG_TARGET_Y:       target_y_q       <= cfg_data;
				REG_TARGET_HEADING: target_heading_q <= cfg_data;
				REG_DISTANCE_GAIN:  distance_gain_q  <= cfg_data[15:0];
				REG_HEADING_GAIN:   heading_gain_q   <= cfg_data[15:0];
				REG_WHEEL_BASE:     wheel_base_q     <= cfg_data[30:0];
				REG_WHEEL_RADIUS:   wheel_radius_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// A zero radius is taken as the smallest radius so that the speeds saturate.
	logic [DEN_W-1:0] den;
	assign den = {((wheel_radius_q == '0) ? 31'd1 : wheel_radius_q), 1'b0};

	// The pipeline moves as one while the output holding stage has room.
	logic en;
	logic sk_v_q;
	assign en       = !sk_v_q;
	assign in_ready = en;

	// Stage 1: saturated errors.
	logic        v_s1;
	logic [31:0] ex_s1, ey_s1, eth_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1  <= sat33({target_x_q[31], target_x_q} - {in_data.pose_x[31], in_data.pose_x});
			ey_s1  <= sat33({target_y_q[31], target_y_q} - {in_data.pose_y[31], in_data.pose_y});
			eth_s1 <= sat33({target_heading_q[31], target_heading_q}
			                - {in_data.pose_heading[31], in_data.pose_heading});
		end
	end

	// Stage 2: squares of the position errors and the scaled heading error.
	logic        v_s2;
	logic [63:0] sqx_s2, sqy_s2;
	logic [47:0] wraw_s2;
	logic        neg_s2;
	logic [31:0] ax, ay, ath;
	logic [63:0] sqx, sqy;
	logic [47:0] wraw;

	assign ax   = ex_s1[31]  ? 32'(-ex_s1)  : ex_s1;
	assign ay   = ey_s1[31]  ? 32'(-ey_s1)  : ey_s1;
	assign ath  = eth_s1[31] ? 32'(-eth_s1) : eth_s1;
	assign sqx  = ax * ax;
	assign sqy  = ay * ay;
	assign wraw = heading_gain_q * ath;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= sqx;
			sqy_s2  <= sqy;
			wraw_s2 <= wraw;
			neg_s2  <= eth_s1[31];
		end
	end

	// Stage 3: radicand, and the turn term times the wheel base in two halves.
	logic        v_s3;
	logic [63:0] rad_s3;
	logic [53:0] phi_s3;
	logic [46:0] plo_s3;
	logic        neg_s3;
	logic [53:0] phi;
	logic [46:0] plo;

	assign phi = wraw_s2[46:24] * wheel_base_q;
	assign plo = wraw_s2[23:8] * wheel_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= sqx_s2 + sqy_s2;
			phi_s3 <= phi;
			plo_s3 <= plo;
			neg_s3 <= neg_s2;
		end
	end

	// Stage 4: join the two halves of the turn term.
	logic        v_s4;
	logic [63:0] rad_s4;
	wl_t         wl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4     <= rad_s3;
			wl_s4.neg  <= neg_s3;
			wl_s4.mag  <= WL_W'(phi_s3) + WL_W'(plo_s3[46:16]);
		end
	end

	// Distance: truncated square root, with the turn term riding alongside.
	logic              sq_v;
	logic [ROOT_W-1:0] range_root;
	wl_t               sq_wl;

	ddgp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s4),
		.rad      (rad_s4),
		.side_in  (wl_s4),
		.out_v    (sq_v),
		.root     (range_root),
		.side_out (sq_wl)
	);

	// Stage 5: forward speed product.
	logic        v_s5;
	logic [47:0] vp_s5;
	wl_t         wl_s5;
	logic [47:0] vp;

	assign vp = distance_gain_q * range_root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vp_s5 <= vp;
			wl_s5 <= sq_wl;
		end
	end

	// Stage 6: numerators 2v - wl and 2v + wl.
	logic           v_s6;
	logic [N_W-1:0] nl_s6, nr_s6;
	logic [N_W-1:0] two_v, wls;

	assign two_v = N_W'({vp_s5[47:8], 1'b0});
	assign wls   = wl_s5.neg ? N_W'(-N_W'(wl_s5.mag)) : N_W'(wl_s5.mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nl_s6 <= two_v - wls;
			nr_s6 <= two_v + wls;
		end
	end

	// Stage 7: magnitude, sign and overflow test for each wheel.
	logic     v_s7;
	dv_prep_t pl_s7, pr_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s7 <= prep_lane(nl_s6, den);
			pr_s7 <= prep_lane(nr_s6, den);
		end
	end

	// Wheel speed dividers, one per wheel, in lockstep.
	logic             dl_v, dr_v;
	logic [QUO_W-1:0] ql, qr;
	dv_side_t         sl, sr;

	ddgp_div u_div_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s7),
		.prep     (pl_s7),
		.den      (den),
		.out_v    (dl_v),
		.quo      (ql),
		.side_out (sl)
	);

	ddgp_div u_div_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s7),
		.prep     (pr_s7),
		.den      (den),
		.out_v    (dr_v),
		.quo      (qr),
		.side_out (sr)
	);

	// Output register and skid register. A word leaves the dividers whenever the
	// pipeline moves; it lands in the output register if that is free or being
	// emptied, otherwise in the skid register, which then freezes the pipeline.
	speeds_t res;
	speeds_t out_q, sk_q;
	logic    out_v_q;
	logic    push, pop;

	assign res.left_speed  = finish(ql, sl);
	assign res.right_speed = finish(qr, sr);
	assign push            = en && dl_v;
	assign pop             = out_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (sk_v_q) begin
			if (pop) begin
				sk_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				sk_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (pop) begin
				out_q <= sk_q;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				sk_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// The skid register only ever holds a word behind a waiting output word.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid word held with no output word");

	// Both wheel dividers carry the same words.
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dl_v == dr_v)
		else $error("wheel dividers out of step");

	// The skid register drains only when the output word is taken.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sk_v_q) |-> $past(out_valid && out_ready))
		else $error("skid word dropped");

	// A frozen pipeline keeps its last stage.
	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && dl_v) |=> dl_v)
		else $error("word lost during stall");

endmodule

FILE: verif/speeds_checker.sv
module speeds_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  ddgp_pkg::pose_t                 in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  ddgp_pkg::speeds_t               out_data,
	input  logic                            cfg_we,
	input  logic [ddgp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ddgp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              pending
);
	import ddgp_pkg::*;

	logic signed [31:0] goal_x, goal_y, goal_heading;
	logic [15:0]        dist_gain, turn_gain;
	logic [30:0]        base_len, radius_len;
	speeds_t            speeds_due [$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unsigned floor_root(longint unsigned n);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			probe = root | (64'd1 << b);
			// Compare probe squared with n without overflowing 64 bits.
			if (probe <= 64'hFFFFFFFF && probe * probe <= n)
				root = probe;
		end
		return root;
	endfunction

	function automatic logic signed [31:0] wheel_rate(longint n, logic [30:0] r);
		longint unsigned den, m, q, rem, res;
		den = 2 * ((r == 0) ? 64'd1 : {33'd0, r});
		m   = abs64(n);
		q   = m / den;
		rem = m % den;
		if (q >= 64'h10000)
			res = 64'h1_0000_0000;
		else
			res = (q << 16) + ((rem << 16) / den);
		if (n < 0)
			return (res >= 64'h8000_0000) ? 32'sh8000_0000 : -res[31:0];
		return (res > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : res[31:0];
	endfunction

	function automatic speeds_t wheel_speeds(pose_t p);
		longint          ex, ey, eth, fwd, turn, left_n, right_n;
		longint unsigned span, wm, wlm;
		speeds_t         s;
		ex   = clamp32(longint'(goal_x) - longint'(p.pose_x));
		ey   = clamp32(longint'(goal_y) - longint'(p.pose_y));
		eth  = clamp32(longint'(goal_heading) - longint'(p.pose_heading));
		span = floor_root(abs64(ex) * abs64(ex) + abs64(ey) * abs64(ey));
		fwd  = (longint'(dist_gain) * span) >> 8;
		wm   = (longint'(turn_gain) * abs64(eth)) >> 8;
		wlm  = (wm >> 16) * base_len + (((wm & 64'hFFFF) * base_len) >> 16);
		turn = (eth < 0) ? -longint'(wlm) : longint'(wlm);
		left_n  = 2 * fwd - turn;
		right_n = 2 * fwd + turn;
		s.left_speed  = wheel_rate(left_n, radius_len);
		s.right_speed = wheel_rate(right_n, radius_len);
		return s;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("checker: %s mismatch at %0t: got %h, expected %h", field, $time, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		speeds_t want;
		if (!arst_n) begin
			goal_x       = 0;
			goal_y       = 0;
			goal_heading = 0;
			dist_gain    = 16'd384;
			turn_gain    = 16'd1024;
			base_len     = 31'd13107;
			radius_len   = 31'd3277;
			speeds_due.delete();
		end else begin
			if (in_valid && in_ready)
				speeds_due.push_back(wheel_speeds(in_data));
			if (out_valid && out_ready) begin
				if (speeds_due.size() == 0) begin
					$display("checker: unexpected word at %0t", $time);
					errors++;
				end else begin
					want = speeds_due.pop_front();
					if (out_data.left_speed !== want.left_speed)
						report("left_speed", out_data.left_speed, want.left_speed);
					if (out_data.right_speed !== want.right_speed)
						report("right_speed", out_data.right_speed, want.right_speed);
				end
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_TARGET_X:       goal_x       = cfg_data;
					REG_TARGET_Y:       goal_y       = cfg_data;
					REG_TARGET_HEADING: goal_heading = cfg_data;
					REG_DISTANCE_GAIN:  dist_gain    = cfg_data[15:0];
					REG_HEADING_GAIN:   turn_gain    = cfg_data[15:0];
					REG_WHEEL_BASE:     base_len     = cfg_data[30:0];
					REG_WHEEL_RADIUS:   radius_len   = cfg_data[30:0];
					default: ;
				endcase
			end
		end
		pending = speeds_due.size();
	end

endmodule

FILE: verif/testbench.sv
module testbench;
	import ddgp_pkg::*;

	// This pause is longer than the path of a taken word through the block, so it
	// covers any word still in flight with some margin.
	localparam int PIPE_DRAIN = 100;
	// Cycles without any word moving before the run is declared hung.
	localparam int STUCK_LIMIT = 3000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	pose_t                 in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	speeds_t               out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	int                    errors;
	int                    pending;

	// Stimulus-side copy of the target, used to aim poses near it.
	logic signed [31:0] aim_x = 0, aim_y = 0, aim_heading = 0;
	// When set, the matching side never idles, giving stretches of full rate.
	bit source_busy = 0;
	bit sink_busy   = 0;

	always #5 clk = ~clk;

	diff_drive_goto_pose_speeds_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	speeds_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	// Most gaps are short; now and then a long one lets the pipeline drain.
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// The sink stalls in bursts of random length, unless it is told to keep up.
	always @(posedge clk) begin
		int hold;
		if (hold > 0) begin
			out_ready <= 1'b0;
			hold--;
		end else if (!sink_busy && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			hold = idle_span();
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: any word moving on either channel, or a register write, resets it.
	always @(posedge clk) begin
		int quiet;
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= STUCK_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// Holds one word on the pose channel until it is taken. The ready line is
	// looked at on the falling edge, where nothing is changing, and the word
	// counts as taken at the following rising edge. Valid is only lowered
	// when a gap follows, so it never drops and rises within one step.
	task automatic send_pose(pose_t p);
		logic took;
		int   gap;
		in_valid <= 1'b1;
		in_data  <= p;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		gap = source_busy ? 0 : idle_span();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lowers valid and waits until every result has come back and the pipeline
	// is quiet, so that registers may be changed safely.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (reg_idx_t'(idx))
			REG_TARGET_X:       aim_x       = value;
			REG_TARGET_Y:       aim_y       = value;
			REG_TARGET_HEADING: aim_heading = value;
			default: ;
		endcase
	endtask

	// A pose somewhere around the target, with offsets of every scale.
	function automatic logic signed [31:0] near(logic signed [31:0] centre);
		longint off;
		off = longint'($urandom_range(0, (1 << $urandom_range(0, 24)) - 1));
		if ($urandom_range(0, 1))
			off = -off;
		return 32'(longint'(centre) + off);
	endfunction

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic pose_t random_pose();
		pose_t p;
		int    mode;
		mode = $urandom_range(0, 9);
		if (mode < 3) begin
			p = {$urandom, $urandom, $urandom};
		end else if (mode < 9) begin
			p.pose_x       = near(aim_x);
			p.pose_y       = near(aim_y);
			p.pose_heading = near(aim_heading);
		end else begin
			p = {edge_value(), edge_value(), edge_value()};
		end
		return p;
	endfunction

	// Random register values, most of them plausible, some at the limits.
	task automatic random_setup();
		write_reg(REG_TARGET_X, $urandom_range(0, 3) == 0 ? edge_value() : near(0));
		write_reg(REG_TARGET_Y, $urandom_range(0, 3) == 0 ? edge_value() : near(0));
		write_reg(REG_TARGET_HEADING, $urandom_range(0, 3) == 0 ? edge_value() : near(0));
		write_reg(REG_DISTANCE_GAIN, $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 2048));
		write_reg(REG_HEADING_GAIN, $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 2048));
		write_reg(REG_WHEEL_BASE, $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 65536));
		write_reg(REG_WHEEL_RADIUS, $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 65536));
	endtask

	initial begin
		pose_t p;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset settings: the pose at the origin, the extremes
		// of every field so that the differences saturate, all-ones, and mixed words.
		send_pose('0);
		send_pose({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		send_pose({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		send_pose({32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000});
		send_pose({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_pose({32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000});
		send_pose({32'h0000_0000, 32'hFFFF_0000, 32'h0003_243F});
		settle();

		// Targets at opposite extremes, largest gains, the smallest base and the largest
		// radius, so that the error differences saturate.
		write_reg(REG_TARGET_X, 32'h8000_0000);
		write_reg(REG_TARGET_Y, 32'h7FFF_FFFF);
		write_reg(REG_TARGET_HEADING, 32'h8000_0000);
		write_reg(REG_DISTANCE_GAIN, 32'hFFFF);
		write_reg(REG_HEADING_GAIN, 32'hFFFF);
		write_reg(REG_WHEEL_BASE, 32'h1);
		write_reg(REG_WHEEL_RADIUS, 32'h7FFF_FFFF);
		// An index beyond the last register must change nothing.
		write_reg(3'd7, 32'hDEAD_BEEF);
		send_pose({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
		send_pose({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
		send_pose('0);
		settle();

		// Zero gains give zero speed; the widest base and a radius of zero,
		// reached by a write whose only set bit lies above the register,
		// which the block must treat as the smallest radius.
		write_reg(REG_DISTANCE_GAIN, 32'hFFFF_0000);
		write_reg(REG_HEADING_GAIN, 32'h0);
		write_reg(REG_WHEEL_BASE, 32'hFFFF_FFFF);
		write_reg(REG_WHEEL_RADIUS, 32'h8000_0000);
		send_pose({32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF});
		settle();
		write_reg(REG_HEADING_GAIN, 32'h0000_0100);
		send_pose({32'h0, 32'h0, 32'h7FFF_FFFF});
		send_pose({32'h0, 32'h0, 32'h0000_0001});
		send_pose({32'h0, 32'h0, 32'h8000_0000});
		settle();

		// A radius of one, then back to the reset settings, with poses close
		// to the target so that the speeds stay in range.
		write_reg(REG_WHEEL_RADIUS, 32'h1);
		write_reg(REG_TARGET_X, 32'h0);
		write_reg(REG_TARGET_Y, 32'h0);
		write_reg(REG_TARGET_HEADING, 32'h0);
		send_pose({32'h0000_0001, 32'h0, 32'h0});
		settle();
		write_reg(REG_DISTANCE_GAIN, 32'd384);
		write_reg(REG_HEADING_GAIN, 32'd1024);
		write_reg(REG_WHEEL_BASE, 32'd13107);
		write_reg(REG_WHEEL_RADIUS, 32'd3277);
		send_pose({32'h0001_8000, 32'hFFFF_4000, 32'h0000_8000});
		send_pose({32'hFFFE_0000, 32'h0002_0000, 32'hFFFF_8000});
		settle();

		// Random part: eleven settings of about 120 words each. Some phases
		// run one side or both at full rate, the rest idle at random.
		for (int ph = 0; ph < 11; ph++) begin
			if (ph > 0)
				random_setup();
			source_busy = ($urandom_range(0, 3) == 0);
			sink_busy   = ($urandom_range(0, 3) == 0);
			repeat (120) begin
				p = random_pose();
				send_pose(p);
			end
			settle();
		end
		source_busy = 0;
		sink_busy   = 0;

		if (errors == 0 && pending == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
